[rtl/trgf_pkg.sv]
// Shared types and constants for the touch release glitch filter.
// Used by every module under rtl/; depends on nothing.
`timescale 1ns / 1ps

package trgf_pkg;

    // Frame buffer geometry
    localparam int FRAME_DEPTH = 64;
    localparam int MAX_RESULTS = 64;
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);
    localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);
    localparam int TAKE_W      = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Event codes
    localparam logic [15:0] EVT_SYN     = 16'd0;
    localparam logic [15:0] EVT_KEY     = 16'd1;
    localparam logic [15:0] EVT_ABS     = 16'd3;
    localparam logic [15:0] CODE_REPORT = 16'd0;
    localparam logic [15:0] CODE_TOUCH  = 16'd330;
    localparam logic [15:0] CODE_TRACK  = 16'd57;

    // Input kinds
    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Configuration register indexes
    localparam logic [7:0] CFG_MIN_HOLD  = 8'd0;
    localparam logic [7:0] CFG_SUP_TMO   = 8'd1;
    localparam logic [7:0] CFG_MAX_REARM = 8'd2;
    localparam logic [7:0] CFG_KEEPALIVE = 8'd3;

    // Configuration reset values
    localparam logic [15:0] RST_MIN_HOLD  = 16'd280;
    localparam logic [15:0] RST_SUP_TMO   = 16'd600;
    localparam logic [3:0]  RST_MAX_REARM = 4'd12;
    localparam logic [15:0] RST_KEEPALIVE = 16'd200;

    // One unit of work handed from the front end to the back end
    typedef struct packed {
        logic             send;      // a stored frame is to be forwarded
        logic             bank;      // buffer bank that holds the frame
        logic [CNT_W-1:0] count;     // stored events in the frame
        logic             filt;      // drop touch-key and tracking-id events
        logic             rearm;     // re-arm request on the final beat
        logic             touching;  // touch flag after this item
    } t_job;

    // Job completion reported back to the front end
    typedef struct packed {
        logic pop;
        logic send;
        logic bank;
    } t_done;

endpackage

[rtl/touch_release_glitch_filter.sv]
// Top level of the touch release glitch filter: front end, job queue and
// back end with its frame buffer. Depends on trgf_pkg and the trgf_* modules.
//
//   channel  direction  handshake                 payload
//   s        in         i_s_tvalid / o_s_tready   tdata {ev_value, ev_code, ev_type}, tuser op
//   m        out        o_m_tvalid / i_m_tready   tdata {out_value, out_code, out_type},
//                                                 tuser {touching, rearm, has_event}, tlast
//   cfg      in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// The front end takes one item per cycle while the two-entry job queue has room.
// For each stored event of a forwarded frame the back end does one buffer read
// and one check, and it ends every item with one final beat.
// An event waits while a queued job still reads the bank it would write.
// Reset is synchronous and active low; the frame buffer needs no clearing.
`timescale 1ns / 1ps

module touch_release_glitch_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // ev_type [15:0], ev_code [31:16], ev_value [63:32]
    input  logic        i_s_tuser,   // op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // out_type [15:0], out_code [31:16], out_value [63:32]
    output logic [2:0]  o_m_tuser,   // has_event [0], rearm [1], touching [2]
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import trgf_pkg::*;

    logic              q_full, q_push, q_valid;
    t_job              q_in, q_out;
    t_done             done;
    logic              wr_en;
    logic [ADDR_W:0]   wr_addr;
    logic [63:0]       wr_data;

    // Front end: classification and filter state
    trgf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_job     (q_in),
        .i_done      (done),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    // Job queue
    trgf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (done.pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_out)
    );

    // Back end: frame buffer and output beats
    trgf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_job_valid (q_valid),
        .i_job       (q_out),
        .o_done      (done),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

[rtl/trgf_queue.sv]
// Two-entry job queue between the front end and the back end.
// Depends on trgf_pkg.
`timescale 1ns / 1ps

module trgf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  trgf_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output trgf_pkg::t_job o_job
);
    import trgf_pkg::*;

    t_job              r_slot [QUEUE_DEPTH];
    logic              r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_slot[r_rp];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wp] <= i_job;
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop)) else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("job queue underflow");
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QUEUE_DEPTH)) else $error("job queue level out of range");
`endif

endmodule

[rtl/trgf_front.sv]
// Front end: accepts events and ticks, keeps the filter state and config,
// writes the frame buffer and issues one job per item. Depends on trgf_pkg.
`timescale 1ns / 1ps

module trgf_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [63:0]               i_s_tdata,
    input  logic                      i_s_tuser,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [7:0]                i_cfg_index,
    input  logic [15:0]               i_cfg_data,
    input  logic                      i_q_full,
    output logic                      o_q_push,
    output trgf_pkg::t_job            o_q_job,
    input  trgf_pkg::t_done           i_done,
    output logic                      o_wr_en,
    output logic [trgf_pkg::ADDR_W:0] o_wr_addr,
    output logic [63:0]               o_wr_data
);
    import trgf_pkg::*;

    typedef enum logic [1:0] {
        MODE_FWD = 2'b01,
        MODE_SUP = 2'b10
    } t_mode;

    // Configuration
    logic [15:0] r_min_hold, r_sup_tmo, r_keepalive;
    logic [3:0]  r_max_rearm;

    // Filter state
    t_mode            r_mode, n_mode;
    logic [CNT_W-1:0] r_fc, n_fc, r_hc, n_hc;
    logic             r_up, n_up, r_down, n_down;
    logic             r_fbank, n_fbank, r_hbank, n_hbank;
    logic [15:0]      r_hold, n_hold, r_sup, n_sup, r_keep, n_keep;
    logic [3:0]       r_rc, n_rc;
    logic             r_touch, n_touch;
    logic [1:0]       r_bcnt [2];

    logic [15:0] ev_type, ev_code;
    logic [31:0] ev_value;
    logic        accept, stored, is_up, is_down;
    t_job        job;

    assign ev_type  = i_s_tdata[15:0];
    assign ev_code  = i_s_tdata[31:16];
    assign ev_value = i_s_tdata[63:32];

    // An event may only write the frame bank once no job still reads it
    assign o_s_tready  = !i_q_full && (i_s_tuser == OP_TICK || r_bcnt[r_fbank] == 2'd0);
    assign accept      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    assign stored  = (r_fc < CNT_W'(FRAME_DEPTH));
    assign is_up   = (ev_type == EVT_KEY) && (ev_code == CODE_TOUCH) && (ev_value == 32'd0);
    assign is_down = (ev_type == EVT_KEY) && (ev_code == CODE_TOUCH) && (ev_value == 32'd1);

    assign o_wr_en   = accept && (i_s_tuser == OP_EVENT) && stored;
    assign o_wr_addr = {r_fbank, r_fc[ADDR_W-1:0]};
    assign o_wr_data = {ev_type, ev_code, ev_value};
    assign o_q_push  = accept;
    assign o_q_job   = job;

    // Next state for one accepted item
    always_comb begin
        n_mode  = r_mode;
        n_fc    = r_fc;
        n_hc    = r_hc;
        n_up    = r_up;
        n_down  = r_down;
        n_fbank = r_fbank;
        n_hbank = r_hbank;
        n_hold  = r_hold;
        n_sup   = r_sup;
        n_keep  = r_keep;
        n_rc    = r_rc;
        n_touch = r_touch;
        job     = '0;
        if (i_s_tuser == OP_TICK) begin
            if (r_hold != 16'hFFFF) n_hold = r_hold + 16'd1;
            if (r_mode == MODE_SUP) begin
                if (r_sup != 16'hFFFF) n_sup = r_sup + 16'd1;
                if (n_sup >= r_sup_tmo) begin
                    // Timeout: the held release goes out as real
                    job.send  = 1'b1;
                    job.bank  = r_hbank;
                    job.count = r_hc;
                    n_hc      = '0;
                    n_mode    = MODE_FWD;
                    n_touch   = 1'b0;
                end
            end
            if (r_keep != 16'hFFFF) n_keep = r_keep + 16'd1;
            if (n_keep >= r_keepalive) begin
                n_keep = 16'd0;
                if (!n_touch) job.rearm = 1'b1;
            end
        end else begin
            if (is_up && r_mode == MODE_FWD && r_hold >= r_min_hold && r_rc < r_max_rearm) begin
                job.rearm = 1'b1;
                n_rc      = r_rc + 4'd1;
            end
            if (stored) begin
                n_fc   = r_fc + 1'b1;
                n_up   = r_up || is_up;
                n_down = r_down || is_down;
            end
            // Report sync closes the frame
            if (ev_type == EVT_SYN && ev_code == CODE_REPORT) begin
                job.bank  = r_fbank;
                job.count = n_fc;
                if (r_mode == MODE_FWD) begin
                    if (n_up) begin
                        if (r_hold < r_min_hold || n_rc >= r_max_rearm) begin
                            job.send = 1'b1;
                            n_touch  = 1'b0;
                            n_rc     = 4'd0;
                        end else begin
                            // Hold the release back: the frame bank becomes the held bank
                            n_hbank = r_fbank;
                            n_fbank = ~r_fbank;
                            n_hc    = n_fc;
                            n_sup   = 16'd0;
                            n_mode  = MODE_SUP;
                        end
                    end else begin
                        job.send = 1'b1;
                        if (n_down) begin
                            n_touch = 1'b1;
                            n_hold  = 16'd0;
                            n_rc    = 4'd0;
                        end
                    end
                end else begin
                    job.send = 1'b1;
                    if (n_down) begin
                        job.filt = 1'b1;
                        n_hc     = '0;
                        n_mode   = MODE_FWD;
                        n_touch  = 1'b1;
                    end
                end
                n_fc   = '0;
                n_up   = 1'b0;
                n_down = 1'b0;
            end
        end
        job.touching = n_touch;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_FWD;
            r_fc    <= '0;
            r_hc    <= '0;
            r_up    <= 1'b0;
            r_down  <= 1'b0;
            r_fbank <= 1'b0;
            r_hbank <= 1'b1;
            r_hold  <= 16'hFFFF;
            r_sup   <= 16'd0;
            r_keep  <= 16'd0;
            r_rc    <= 4'd0;
            r_touch <= 1'b0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_fc    <= n_fc;
            r_hc    <= n_hc;
            r_up    <= n_up;
            r_down  <= n_down;
            r_fbank <= n_fbank;
            r_hbank <= n_hbank;
            r_hold  <= n_hold;
            r_sup   <= n_sup;
            r_keep  <= n_keep;
            r_rc    <= n_rc;
            r_touch <= n_touch;
        end
    end

    // Outstanding forwarding jobs per bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt[0] <= 2'd0;
            r_bcnt[1] <= 2'd0;
        end else begin
            for (int b = 0; b < 2; b++) begin
                case ({accept && job.send && (job.bank == 1'(b)),
                       i_done.pop && i_done.send && (i_done.bank == 1'(b))})
                    2'b10:   r_bcnt[b] <= r_bcnt[b] + 2'd1;
                    2'b01:   r_bcnt[b] <= r_bcnt[b] - 2'd1;
                    default: r_bcnt[b] <= r_bcnt[b];
                endcase
            end
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_hold  <= RST_MIN_HOLD;
            r_sup_tmo   <= RST_SUP_TMO;
            r_max_rearm <= RST_MAX_REARM;
            r_keepalive <= RST_KEEPALIVE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MIN_HOLD:  r_min_hold  <= i_cfg_data;
                CFG_SUP_TMO:   r_sup_tmo   <= i_cfg_data;
                CFG_MAX_REARM: r_max_rearm <= i_cfg_data[3:0];
                CFG_KEEPALIVE: r_keepalive <= i_cfg_data;
                default: ;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_event_bank_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (r_bcnt[r_fbank] == 2'd0)) else $error("write into a bank in use");
    a_banks_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fbank != r_hbank) else $error("frame and held bank coincide");
    a_frame_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_s_tuser == OP_EVENT && ev_type == EVT_SYN && ev_code == CODE_REPORT)
        |=> (r_fc == '0)) else $error("frame not cleared after sync");
`endif

endmodule

[rtl/trgf_back.sv]
// Back end: holds the two-bank frame buffer and drains jobs into the
// output register, one stored event per read. Depends on trgf_pkg.
`timescale 1ns / 1ps

module trgf_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  logic [trgf_pkg::ADDR_W:0] i_wr_addr,
    input  logic [63:0]               i_wr_data,
    input  logic                      i_job_valid,
    input  trgf_pkg::t_job            i_job,
    output trgf_pkg::t_done           o_done,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [63:0]               o_m_tdata,
    output logic [2:0]                o_m_tuser,
    output logic                      o_m_tlast
);
    import trgf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_CHK  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    logic [63:0] r_mem [2*FRAME_DEPTH];
    logic [63:0] r_rd_data;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [TAKE_W-1:0] r_taken, n_taken;
    logic              r_pend_v, n_pend_v;
    logic [63:0]       r_pend, n_pend;

    logic        r_ov, r_ohas, r_orearm, r_otouch, r_olast;
    logic [63:0] r_odata;

    logic        slot_free, rd_en, cand, at_end, push, push_has, push_last;
    logic [63:0] push_data;

    assign slot_free = !r_ov || i_m_tready;
    assign at_end    = (r_idx + 1'b1 == i_job.count);

    // Frame buffer: one write port from the front end, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
        if (rd_en) r_rd_data <= r_mem[{i_job.bank, r_idx[ADDR_W-1:0]}];
    end

    // Scan control; a candidate is kept pending until the next one proves it is not last
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_taken   = r_taken;
        n_pend_v  = r_pend_v;
        n_pend    = r_pend;
        rd_en     = 1'b0;
        push      = 1'b0;
        push_has  = r_pend_v;
        push_last = 1'b0;
        push_data = r_pend;
        o_done    = '0;
        cand      = !(i_job.filt &&
                      ((r_rd_data[63:48] == EVT_KEY && r_rd_data[47:32] == CODE_TOUCH) ||
                       (r_rd_data[63:48] == EVT_ABS && r_rd_data[47:32] == CODE_TRACK)))
                    && (r_taken < TAKE_W'(MAX_RESULTS));
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_idx    = '0;
                    n_taken  = '0;
                    n_pend_v = 1'b0;
                    n_state  = (i_job.send && i_job.count != '0) ? S_RD : S_FIN;
                end
            end
            S_RD: begin
                rd_en   = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (!(cand && r_pend_v && !slot_free)) begin
                    if (cand) begin
                        push     = r_pend_v;
                        n_pend   = r_rd_data;
                        n_pend_v = 1'b1;
                        n_taken  = r_taken + 1'b1;
                    end
                    n_idx   = r_idx + 1'b1;
                    n_state = at_end ? S_FIN : S_RD;
                end
            end
            S_FIN: begin
                if (slot_free) begin
                    push        = 1'b1;
                    push_last   = 1'b1;
                    o_done.pop  = 1'b1;
                    o_done.send = i_job.send;
                    o_done.bank = i_job.bank;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (!push_has) push_data = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pend_v <= n_pend_v;
        end
        r_idx   <= n_idx;
        r_taken <= n_taken;
        r_pend  <= n_pend;
    end

    // Output register: a beat waits here while the scan goes on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (push) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
        if (push) begin
            r_odata  <= push_data;
            r_ohas   <= push_has;
            r_orearm <= push_last && i_job.rearm;
            r_otouch <= i_job.touching;
            r_olast  <= push_last;
        end
    end

    // Stored events keep the type in the top bits; the bus puts it lowest
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {r_odata[31:0], r_odata[47:32], r_odata[63:48]};
    assign o_m_tuser  = {r_otouch, r_orearm, r_ohas};
    assign o_m_tlast  = r_olast;

`ifndef ASSERT_OFF
    a_job_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> i_job_valid) else $error("scan without a job");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> (r_idx < i_job.count)) else $error("scan past frame end");
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> slot_free) else $error("output beat overwritten");
    a_empty_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !push_last) |-> r_pend_v) else $error("inner beat without data");
`endif

endmodule
